// File: hdl/cbfg_pkg.sv
// ----------------------------------------------------------------------------
// cbfg_pkg
// Types and constants shared by the circuit breaker fault gate.
// ----------------------------------------------------------------------------
package cbfg_pkg;

    localparam int unsigned CNT_WIDTH_DEF   = 32;
    localparam int unsigned RESULT_WIDTH    = 32;
    localparam int unsigned CLOSE_SUCCESSES = 3;

    localparam logic [7:0]  THRESHOLD_RESET = 8'd5;
    localparam logic [31:0] TIMEOUT_RESET   = 32'd30;

    typedef enum logic [1:0] {
        GATE_CLOSED = 2'd0,
        GATE_OPEN   = 2'd1,
        GATE_HALF   = 2'd2
    } t_gate_state;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_CALL  = 2'd1,
        MODE_CLEAR = 2'd2
    } t_mode;

    localparam logic [1:0] OUTCOME_SUCCESS   = 2'd0;
    localparam logic [1:0] OUTCOME_EXCEPTION = 2'd2;

    localparam logic CFG_THRESHOLD = 1'b0;
    localparam logic CFG_TIMEOUT   = 1'b1;

endpackage

// File: hdl/circuit_breaker_fault_gate.sv
// ----------------------------------------------------------------------------
// circuit_breaker_fault_gate
// Three-state fault gate (closed, open, half-open) with saturating statistics.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                    Payload
// input     in         i_in_valid / o_in_ready      i_mode, i_outcome
// result    out        o_out_valid / i_out_ready    o_gate_state .. o_transition_total
// config    in         i_cfg_we                     i_cfg_index, i_cfg_data
//
// Each item is processed combinationally and its result is valid in the cycle after it is accepted.
// A new item is accepted every cycle while the result register is empty or its result is taken in the same cycle.
// The result register holds while the output is stalled, and input is then held off.
// Reset is synchronous and active low; it restores the registers and clears all state.
// ----------------------------------------------------------------------------
module circuit_breaker_fault_gate
    import cbfg_pkg::*;
#(
    parameter int unsigned COUNTER_WIDTH = CNT_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [1:0]  i_outcome,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_gate_state,
    output logic        o_admitted,
    output logic [31:0] o_call_total,
    output logic [31:0] o_success_total,
    output logic [31:0] o_failure_total,
    output logic [31:0] o_fast_fail_total,
    output logic [31:0] o_exception_total,
    output logic [31:0] o_transition_total
);

    typedef logic [COUNTER_WIDTH-1:0] t_cnt;

    logic [7:0]  r_threshold;
    logic [31:0] r_timeout;

    t_gate_state r_gate,       n_gate;
    logic [7:0]  r_fail_run,   n_fail_run;
    logic [7:0]  r_ok_run,     n_ok_run;
    logic [31:0] r_ticks,      n_ticks;
    t_cnt        r_call_cnt,   n_call_cnt;
    t_cnt        r_ok_cnt,     n_ok_cnt;
    t_cnt        r_bad_cnt,    n_bad_cnt;
    t_cnt        r_reject_cnt, n_reject_cnt;
    t_cnt        r_exc_cnt,    n_exc_cnt;
    t_cnt        r_chg_cnt,    n_chg_cnt;
    logic        r_admitted,   n_admitted;
    logic        r_out_valid;

    logic        in_accept;

    function automatic t_cnt sat_inc(input t_cnt value);
        return (value != '1) ? value + t_cnt'(1) : value;
    endfunction

    function automatic logic [7:0] sat_inc8(input logic [7:0] value);
        return (value != 8'hFF) ? value + 8'd1 : value;
    endfunction

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;

    always_comb begin
        t_gate_state           mid_gate;
        logic [7:0]            ok_next;
        logic [7:0]            fail_next;
        logic [1:0]            chg_inc;
        logic [COUNTER_WIDTH:0] chg_sum;

        n_gate       = r_gate;
        n_fail_run   = r_fail_run;
        n_ok_run     = r_ok_run;
        n_ticks      = r_ticks;
        n_call_cnt   = r_call_cnt;
        n_ok_cnt     = r_ok_cnt;
        n_bad_cnt    = r_bad_cnt;
        n_reject_cnt = r_reject_cnt;
        n_exc_cnt    = r_exc_cnt;
        n_chg_cnt    = r_chg_cnt;
        n_admitted   = 1'b0;
        mid_gate     = r_gate;
        ok_next      = sat_inc8(r_ok_run);
        fail_next    = sat_inc8(r_fail_run);
        chg_inc      = 2'd0;
        chg_sum      = '0;

        case (t_mode'(i_mode))
            MODE_TICK: begin
                n_ticks = (r_ticks != 32'hFFFF_FFFF) ? r_ticks + 32'd1 : r_ticks;
            end
            MODE_CALL: begin
                if (r_gate == GATE_OPEN && r_ticks < r_timeout) begin
                    n_reject_cnt = sat_inc(r_reject_cnt);
                end else begin
                    if (r_gate == GATE_OPEN) begin
                        mid_gate = GATE_HALF;
                        chg_inc  = chg_inc + 2'd1;
                    end
                    n_gate     = mid_gate;
                    n_call_cnt = sat_inc(r_call_cnt);
                    if (i_outcome == OUTCOME_SUCCESS) begin
                        n_admitted = 1'b1;
                        n_ok_cnt   = sat_inc(r_ok_cnt);
                        n_ok_run   = ok_next;
                        if (mid_gate == GATE_HALF) begin
                            if (ok_next >= 8'(CLOSE_SUCCESSES)) begin
                                n_gate     = GATE_CLOSED;
                                n_fail_run = 8'd0;
                                n_ok_run   = 8'd0;
                                chg_inc    = chg_inc + 2'd1;
                            end
                        end else if (mid_gate == GATE_CLOSED) begin
                            n_fail_run = 8'd0;
                        end
                    end else begin
                        if (i_outcome == OUTCOME_EXCEPTION) begin
                            n_exc_cnt = sat_inc(r_exc_cnt);
                        end
                        n_fail_run = fail_next;
                        n_bad_cnt  = sat_inc(r_bad_cnt);
                        n_ticks    = 32'd0;
                        if (fail_next >= r_threshold) begin
                            if (mid_gate != GATE_OPEN) begin
                                n_gate  = GATE_OPEN;
                                chg_inc = chg_inc + 2'd1;
                            end
                            n_ok_run = 8'd0;
                        end
                    end
                end
                chg_sum   = {1'b0, r_chg_cnt} + (COUNTER_WIDTH + 1)'(chg_inc);
                n_chg_cnt = chg_sum[COUNTER_WIDTH] ? '1 : chg_sum[COUNTER_WIDTH-1:0];
            end
            MODE_CLEAR: begin
                n_gate       = GATE_CLOSED;
                n_fail_run   = 8'd0;
                n_ok_run     = 8'd0;
                n_call_cnt   = '0;
                n_ok_cnt     = '0;
                n_bad_cnt    = '0;
                n_reject_cnt = '0;
                n_exc_cnt    = '0;
                n_chg_cnt    = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RESET;
            r_timeout   <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_THRESHOLD: r_threshold <= i_cfg_data[7:0];
                CFG_TIMEOUT:   r_timeout   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate       <= GATE_CLOSED;
            r_fail_run   <= 8'd0;
            r_ok_run     <= 8'd0;
            r_ticks      <= 32'd0;
            r_call_cnt   <= '0;
            r_ok_cnt     <= '0;
            r_bad_cnt    <= '0;
            r_reject_cnt <= '0;
            r_exc_cnt    <= '0;
            r_chg_cnt    <= '0;
            r_admitted   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (in_accept) begin
                r_gate       <= n_gate;
                r_fail_run   <= n_fail_run;
                r_ok_run     <= n_ok_run;
                r_ticks      <= n_ticks;
                r_call_cnt   <= n_call_cnt;
                r_ok_cnt     <= n_ok_cnt;
                r_bad_cnt    <= n_bad_cnt;
                r_reject_cnt <= n_reject_cnt;
                r_exc_cnt    <= n_exc_cnt;
                r_chg_cnt    <= n_chg_cnt;
                r_admitted   <= n_admitted;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_gate_state       = r_gate;
    assign o_admitted         = r_admitted;
    assign o_call_total       = RESULT_WIDTH'(r_call_cnt);
    assign o_success_total    = RESULT_WIDTH'(r_ok_cnt);
    assign o_failure_total    = RESULT_WIDTH'(r_bad_cnt);
    assign o_fast_fail_total  = RESULT_WIDTH'(r_reject_cnt);
    assign o_exception_total  = RESULT_WIDTH'(r_exc_cnt);
    assign o_transition_total = RESULT_WIDTH'(r_chg_cnt);

    a_admit_not_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_admitted |-> r_gate != GATE_OPEN)
        else $error("Admitted call reported with the gate open.");

    a_open_ok_run_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gate == GATE_OPEN |-> r_ok_run == 8'd0)
        else $error("Success run is not zero while the gate is open.");

    a_tick_keeps_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && i_mode == MODE_TICK |=> $stable(r_gate) && !r_admitted)
        else $error("Tick changed the gate state or admitted a call.");

    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && i_mode == MODE_CLEAR |=>
            r_gate == GATE_CLOSED && r_call_cnt == '0 && r_chg_cnt == '0)
        else $error("Clear did not restore the closed state and statistics.");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_in_ready)
        else $error("Input held off with an empty result register.");

endmodule

// File: bench/circuit_breaker_fault_gate_tb.sv
// ----------------------------------------------------------------------------
// circuit_breaker_fault_gate_tb
// Self-checking bench for the three-state fault gate. A short directed script
// walks every state change and corner of the gate, then random runs of
// failure streaks, tick runs, success runs and noise are played under several
// threshold and timeout settings. An item-level predictor forecasts every
// result, and each result transfer is compared field by field.
// ----------------------------------------------------------------------------
module circuit_breaker_fault_gate_tb;
    import cbfg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_UNUSED     = 2'd3;
    localparam logic [1:0] OUTCOME_FAILURE = 2'd1;
    localparam logic [1:0] OUTCOME_UNUSED  = 2'd3;
    localparam int unsigned PHASE_ITEMS    = 260;

    typedef enum logic [1:0] {
        ROW_ITEM = 2'd0,
        ROW_PIN  = 2'd1,
        ROW_CFG  = 2'd2
    } t_row_kind;

    typedef enum logic [1:0] {
        RX_FLOW   = 2'd0,
        RX_EVERY4 = 2'd1,
        RX_COIN   = 2'd2,
        RX_BURSTY = 2'd3
    } t_rx_style;

    typedef struct packed {
        logic [1:0]  state;
        logic        admitted;
        logic [31:0] calls;
        logic [31:0] oks;
        logic [31:0] fails;
        logic [31:0] fast_fails;
        logic [31:0] exceptions;
        logic [31:0] transitions;
    } t_gate_report;

    typedef struct packed {
        t_row_kind   kind;
        logic [1:0]  mode;
        logic [1:0]  outcome;
        t_gate_state st;
        logic        adm;
        logic        cfg_idx;
        logic [31:0] cfg_val;
    } t_script_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [31:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_mode = '0;
    logic [1:0]  i_outcome = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_gate_state;
    logic        o_admitted;
    logic [31:0] o_call_total;
    logic [31:0] o_success_total;
    logic [31:0] o_failure_total;
    logic [31:0] o_fast_fail_total;
    logic [31:0] o_exception_total;
    logic [31:0] o_transition_total;

    circuit_breaker_fault_gate DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_mode             (i_mode),
        .i_outcome          (i_outcome),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_gate_state       (o_gate_state),
        .o_admitted         (o_admitted),
        .o_call_total       (o_call_total),
        .o_success_total    (o_success_total),
        .o_failure_total    (o_failure_total),
        .o_fast_fail_total  (o_fast_fail_total),
        .o_exception_total  (o_exception_total),
        .o_transition_total (o_transition_total)
    );

    // Predicted gate state and configuration.
    logic [7:0]   cfg_threshold;
    logic [31:0]  cfg_timeout;
    t_gate_state  gate_st;
    logic [7:0]   fail_streak;
    logic [7:0]   ok_streak;
    logic [31:0]  ticks_quiet;
    logic [31:0]  n_calls, n_ok, n_bad, n_fast, n_exc, n_trans;

    t_gate_report reports_due [$];
    int unsigned  mismatches = 0;
    int unsigned  burst_left = 0;
    int unsigned  rx_tick = 0;
    int unsigned  rx_stall = 0;
    t_rx_style    rx_style = RX_FLOW;

    logic [7:0]  phase_thr [6] = '{8'd1, 8'd3, 8'd5, 8'd255, 8'd0, 8'd2};
    logic [31:0] phase_to  [6] = '{32'd0, 32'd4, 32'd30, 32'd2, 32'd7, 32'd1};

    t_script_row script [0:30] = '{
        '{ROW_CFG,  MODE_TICK,   OUTCOME_SUCCESS,   GATE_CLOSED, 1'b0, CFG_THRESHOLD, 32'd2},
        '{ROW_CFG,  MODE_TICK,   OUTCOME_SUCCESS,   GATE_CLOSED, 1'b0, CFG_TIMEOUT,   32'd2},
        '{ROW_PIN,  MODE_TICK,   OUTCOME_SUCCESS,   GATE_CLOSED, 1'b0, CFG_THRESHOLD, 32'd0},
        '{ROW_PIN,  MODE_CALL,   OUTCOME_SUCCESS,   GATE_CLOSED, 1'b1, CFG_THRESHOLD, 32'd0},
        '{ROW_ITEM, MODE_CALL,   OUTCOME_FAILURE,   GATE_CLOSED, 1'b0, CFG_THRESHOLD, 32'd0},
        '{ROW_PIN,  MODE_CALL,   OUTCOME_EXCEPTION, GATE_OPEN,   1'b0, CFG_THRESHOLD, 32'd0},
        '{ROW_PIN,  MODE_CALL,   OUTCOME_SUCCESS,   GATE_OPEN,   1'b0, CFG_THRESHOLD, 32'd0},
        '{ROW_PIN,  MODE_UNUSED, OUTCOME_SUCCESS,   GATE_OPEN,   1'b0, CFG_THRESHOLD, 32'd0},
        '{ROW_ITEM, MODE_TICK,   OUTCOME_UNUSED,    GATE_CLOSED, 1'b0, CFG_THRESHOLD, 32'd0},
        '{ROW_ITEM, MODE_TICK,   OUTCOME_SUCCESS,   GATE_CLOSED, 1'b0, CFG_THRESHOLD, 32'd0},
        '{ROW_PIN,  MODE_CALL,   OUTCOME_SUCCESS,   GATE_HALF,   1'b1, CFG_THRESHOLD, 32'd0},
        '{ROW_ITEM, MODE_CALL,   OUTCOME_SUCCESS,   GATE_CLOSED, 1'b0, CFG_THRESHOLD, 32'd0},
        '{ROW_PIN,  MODE_CALL,   OUTCOME_SUCCESS,   GATE_CLOSED, 1'b1, CFG_THRESHOLD, 32'd0},
        '{ROW_ITEM, MODE_CALL,   OUTCOME_UNUSED,    GATE_CLOSED, 1'b0, CFG_THRESHOLD, 32'd0},
        '{ROW_PIN,  MODE_CALL,   OUTCOME_UNUSED,    GATE_OPEN,   1'b0, CFG_THRESHOLD, 32'd0},
        '{ROW_ITEM, MODE_TICK,   OUTCOME_SUCCESS,   GATE_CLOSED, 1'b0, CFG_THRESHOLD, 32'd0},
        '{ROW_ITEM, MODE_TICK,   OUTCOME_SUCCESS,   GATE_CLOSED, 1'b0, CFG_THRESHOLD, 32'd0},
        '{ROW_PIN,  MODE_CALL,   OUTCOME_SUCCESS,   GATE_HALF,   1'b1, CFG_THRESHOLD, 32'd0},
        '{ROW_PIN,  MODE_CALL,   OUTCOME_FAILURE,   GATE_OPEN,   1'b0, CFG_THRESHOLD, 32'd0},
        '{ROW_PIN,  MODE_CLEAR,  OUTCOME_UNUSED,    GATE_CLOSED, 1'b0, CFG_THRESHOLD, 32'd0},
        '{ROW_ITEM, MODE_CALL,   OUTCOME_FAILURE,   GATE_CLOSED, 1'b0, CFG_THRESHOLD, 32'd0},
        '{ROW_CFG,  MODE_TICK,   OUTCOME_SUCCESS,   GATE_CLOSED, 1'b0, CFG_THRESHOLD, 32'd0},
        '{ROW_CFG,  MODE_TICK,   OUTCOME_SUCCESS,   GATE_CLOSED, 1'b0, CFG_TIMEOUT,   32'd0},
        '{ROW_PIN,  MODE_CALL,   OUTCOME_FAILURE,   GATE_OPEN,   1'b0, CFG_THRESHOLD, 32'd0},
        '{ROW_PIN,  MODE_CALL,   OUTCOME_SUCCESS,   GATE_HALF,   1'b1, CFG_THRESHOLD, 32'd0},
        '{ROW_PIN,  MODE_CALL,   OUTCOME_EXCEPTION, GATE_OPEN,   1'b0, CFG_THRESHOLD, 32'd0},
        '{ROW_CFG,  MODE_TICK,   OUTCOME_SUCCESS,   GATE_CLOSED, 1'b0, CFG_THRESHOLD, 32'd255},
        '{ROW_CFG,  MODE_TICK,   OUTCOME_SUCCESS,   GATE_CLOSED, 1'b0, CFG_TIMEOUT,
            32'hFFFF_FFFF},
        '{ROW_ITEM, MODE_CLEAR,  OUTCOME_SUCCESS,   GATE_CLOSED, 1'b0, CFG_THRESHOLD, 32'd0},
        '{ROW_ITEM, MODE_CALL,   OUTCOME_FAILURE,   GATE_CLOSED, 1'b0, CFG_THRESHOLD, 32'd0},
        '{ROW_ITEM, MODE_TICK,   OUTCOME_SUCCESS,   GATE_CLOSED, 1'b0, CFG_THRESHOLD, 32'd0}
    };

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

    function automatic void clear_gate_stats();
        gate_st     = GATE_CLOSED;
        fail_streak = '0;
        ok_streak   = '0;
        n_calls     = '0;
        n_ok        = '0;
        n_bad       = '0;
        n_fast      = '0;
        n_exc       = '0;
        n_trans     = '0;
    endfunction

    // Advances the predicted gate by one item and returns the report it causes.
    function automatic t_gate_report breaker_step(input logic [1:0] mode,
                                                  input logic [1:0] outcome);
        t_gate_report rpt;
        logic         adm;
        adm = 1'b0;
        case (mode)
            MODE_TICK: begin
                ticks_quiet = sat_inc(ticks_quiet);
            end
            MODE_CALL: begin
                if (gate_st == GATE_OPEN && ticks_quiet < cfg_timeout) begin
                    n_fast = sat_inc(n_fast);
                end else begin
                    if (gate_st == GATE_OPEN) begin
                        gate_st = GATE_HALF;
                        n_trans = sat_inc(n_trans);
                    end
                    n_calls = sat_inc(n_calls);
                    if (outcome == OUTCOME_SUCCESS) begin
                        adm = 1'b1;
                        if (ok_streak != 8'hFF) ok_streak = ok_streak + 8'd1;
                        n_ok = sat_inc(n_ok);
                        if (gate_st == GATE_HALF) begin
                            if (ok_streak >= CLOSE_SUCCESSES) begin
                                gate_st     = GATE_CLOSED;
                                fail_streak = '0;
                                ok_streak   = '0;
                                n_trans     = sat_inc(n_trans);
                            end
                        end else begin
                            fail_streak = '0;
                        end
                    end else begin
                        if (outcome == OUTCOME_EXCEPTION) n_exc = sat_inc(n_exc);
                        if (fail_streak != 8'hFF) fail_streak = fail_streak + 8'd1;
                        n_bad       = sat_inc(n_bad);
                        ticks_quiet = '0;
                        if (fail_streak >= cfg_threshold) begin
                            gate_st   = GATE_OPEN;
                            n_trans   = sat_inc(n_trans);
                            ok_streak = '0;
                        end
                    end
                end
            end
            MODE_CLEAR: begin
                clear_gate_stats();
            end
            default: begin
            end
        endcase
        rpt.state       = gate_st;
        rpt.admitted    = adm;
        rpt.calls       = n_calls;
        rpt.oks         = n_ok;
        rpt.fails       = n_bad;
        rpt.fast_fails  = n_fast;
        rpt.exceptions  = n_exc;
        rpt.transitions = n_trans;
        return rpt;
    endfunction

    // Entered and left just after a falling edge.
    task automatic push_item(input logic [1:0] mode, input logic [1:0] outcome);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_in_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_in_valid = 1'b1;
        i_mode     = mode;
        i_outcome  = outcome;
        do @(posedge i_clk); while (!o_in_ready);
        reports_due = {reports_due, breaker_step(mode, outcome)};
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_in_valid = 1'b0;
        while (reports_due.size() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        wait_idle();
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == CFG_THRESHOLD) cfg_threshold = val[7:0];
        else cfg_timeout = val;
    endtask

    task automatic run_phase(input int unsigned n_items);
        int unsigned sent;
        int unsigned len;
        int unsigned pick;
        logic [1:0]  m;
        logic [1:0]  o;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 9);
            if (pick < 3) begin
                len = cfg_threshold + $urandom_range(0, 2);
                if (len > 12) len = $urandom_range(1, 12);
                repeat (len) begin
                    o = ($urandom_range(0, 3) == 0) ? OUTCOME_EXCEPTION : OUTCOME_FAILURE;
                    push_item(MODE_CALL, o);
                end
            end else if (pick < 5) begin
                len = $urandom_range(0, (cfg_timeout > 40) ? 40 : cfg_timeout + 2);
                repeat (len) push_item(MODE_TICK, 2'($urandom_range(0, 3)));
            end else if (pick < 8) begin
                len = $urandom_range(1, 4);
                repeat (len) push_item(MODE_CALL, OUTCOME_SUCCESS);
            end else begin
                len = $urandom_range(1, 6);
                repeat (len) begin
                    m = 2'($urandom_range(0, 3));
                    if (m == MODE_CLEAR && $urandom_range(0, 3) != 0) m = MODE_CALL;
                    o = 2'($urandom_range(0, 3));
                    push_item(m, o);
                end
            end
            sent += len;
            if ($urandom_range(0, 149) == 0) wait_idle();
        end
    endtask

    always @(negedge i_clk) begin
        rx_tick++;
        if (rx_tick % 128 == 0) rx_style = t_rx_style'($urandom_range(0, 3));
        case (rx_style)
            RX_FLOW: begin
                i_out_ready = 1'b1;
            end
            RX_EVERY4: begin
                i_out_ready = (rx_tick % 4) != 3;
            end
            RX_COIN: begin
                i_out_ready = 1'($urandom_range(0, 1));
            end
            default: begin
                if (rx_stall > 0) begin
                    rx_stall--;
                    i_out_ready = 1'b0;
                end else if ($urandom_range(0, 7) == 0) begin
                    rx_stall = $urandom_range(1, 10);
                    i_out_ready = 1'b0;
                end else begin
                    i_out_ready = 1'b1;
                end
            end
        endcase
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_gate_report want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (reports_due.size() == 0) begin
                $display("%0t: result transfer with no expected result, state %0h",
                         $time, o_gate_state);
                mismatches++;
            end else begin
                want = reports_due[0];
                reports_due.delete(0);
                check_field("gate_state", 32'(want.state), 32'(o_gate_state));
                check_field("admitted", 32'(want.admitted), 32'(o_admitted));
                check_field("call_total", want.calls, o_call_total);
                check_field("success_total", want.oks, o_success_total);
                check_field("failure_total", want.fails, o_failure_total);
                check_field("fast_fail_total", want.fast_fails, o_fast_fail_total);
                check_field("exception_total", want.exceptions, o_exception_total);
                check_field("transition_total", want.transitions, o_transition_total);
            end
        end
    end

    initial begin : stimulus
        cfg_threshold = THRESHOLD_RESET;
        cfg_timeout   = TIMEOUT_RESET;
        ticks_quiet   = '0;
        clear_gate_stats();
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (script[r]) begin
            case (script[r].kind)
                ROW_CFG: begin
                    write_reg(script[r].cfg_idx, script[r].cfg_val);
                end
                default: begin
                    push_item(script[r].mode, script[r].outcome);
                    if (script[r].kind == ROW_PIN) begin
                        reports_due[$].state    = script[r].st;
                        reports_due[$].admitted = script[r].adm;
                    end
                end
            endcase
        end

        for (int p = 0; p < 6; p++) begin
            write_reg(CFG_THRESHOLD, 32'(phase_thr[p]));
            write_reg(CFG_TIMEOUT, phase_to[p]);
            run_phase(PHASE_ITEMS);
        end

        wait_idle();
        repeat (3) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: filelist.f
hdl/cbfg_pkg.sv
hdl/circuit_breaker_fault_gate.sv
bench/circuit_breaker_fault_gate_tb.sv
